FILE: sv/tuq_pkg.sv
// shared types, constants and uid helper for the tag uid report qualifier
package tuq_pkg;

    localparam int CfgWidth = 16;
    localparam int TimeWidth = 32;
    localparam int UidLoWidth = 64;
    localparam int UidHiWidth = 16;
    localparam int UidLenWidth = 4;
    localparam int UidLoBytes = UidLoWidth / 8;

    localparam logic [UidLenWidth-1:0] UidLenMax = 4'd10;

    localparam logic [CfgWidth-1:0] PollIntervalReset = 16'd60;
    localparam logic [CfgWidth-1:0] LeaveTimeoutReset = 16'd500;
    localparam logic [CfgWidth-1:0] RepeatWindowReset = 16'd300;

    typedef enum logic [1:0] {
        REG_POLL_INTERVAL = 2'd0,
        REG_LEAVE_TIMEOUT = 2'd1,
        REG_REPEAT_WINDOW = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_POLL   = 1'b0,
        KIND_IGNORE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [UidLoWidth-1:0]  lo;
        logic [UidHiWidth-1:0]  hi;
        logic [UidLenWidth-1:0] len;
    } uid_t;

    typedef struct packed {
        kind_t                kind;
        logic                 card_seen;
        uid_t                 uid;
        logic [TimeWidth-1:0] now_ms;
        logic [TimeWidth-1:0] duration_ms;
    } item_t;

    typedef struct packed {
        logic [CfgWidth-1:0] poll_interval;
        logic [CfgWidth-1:0] leave_timeout;
        logic [CfgWidth-1:0] repeat_window;
    } cfg_t;

    typedef struct packed {
        logic report;
        uid_t uid;
    } result_t;

    // clamp length to ten bytes and clear bytes beyond it
    function automatic uid_t clean_uid(logic [UidLoWidth-1:0] lo,
                                       logic [UidHiWidth-1:0] hi,
                                       logic [UidLenWidth-1:0] len);
        uid_t                   u;
        logic [UidLenWidth-1:0] n;
        logic [UidLoWidth-1:0]  mlo;
        logic [UidHiWidth-1:0]  mhi;
        n = (len > UidLenMax) ? UidLenMax : len;
        mlo = '0;
        for (int i = 0; i < UidLoBytes; i++)
        begin
            mlo[UidLoWidth-1-8*i -: 8] = (n > UidLenWidth'(i)) ? 8'hFF : 8'h00;
        end
        mhi[15:8] = (n > UidLenWidth'(UidLoBytes)) ? 8'hFF : 8'h00;
        mhi[7:0]  = (n > UidLenWidth'(UidLoBytes + 1)) ? 8'hFF : 8'h00;
        u.lo  = lo & mlo;
        u.hi  = hi & mhi;
        u.len = n;
        return u;
    endfunction

endpackage

FILE: sv/tuq_cfg.sv
// configuration registers: poll interval, leave timeout, repeat window
module tuq_cfg
    import tuq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CfgWidth-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POLL_INTERVAL: cfg_next.poll_interval = cfg_data;
                REG_LEAVE_TIMEOUT: cfg_next.leave_timeout = cfg_data;
                REG_REPEAT_WINDOW: cfg_next.repeat_window = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval <= PollIntervalReset;
            cfg_reg.leave_timeout <= LeaveTimeoutReset;
            cfg_reg.repeat_window <= RepeatWindowReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/tuq_core.sv
// qualification state and decision logic, one request per cycle while go is high
module tuq_core
    import tuq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [TimeWidth-1:0] last_poll_reg, last_poll_next;
    logic                 active_valid_reg, active_valid_next;
    uid_t                 active_uid_reg, active_uid_next;
    logic [TimeWidth-1:0] last_seen_reg, last_seen_next;
    logic                 ignore_armed_reg, ignore_armed_next;
    uid_t                 ignore_uid_reg, ignore_uid_next;
    logic [TimeWidth-1:0] ignore_deadline_reg, ignore_deadline_next;
    uid_t                 last_rep_uid_reg, last_rep_uid_next;
    logic [TimeWidth-1:0] last_rep_time_reg, last_rep_time_next;

    logic [TimeWidth-1:0] since_poll;
    logic [TimeWidth-1:0] since_seen;
    logic [TimeWidth-1:0] since_rep;
    logic                 poll_ok;
    logic                 leave_due;
    logic                 ignore_expire;
    logic                 ignore_hit;
    logic                 active_hit;
    logic                 repeat_hit;
    logic                 rep_fire;

    assign since_poll = item.now_ms - last_poll_reg;
    assign since_seen = item.now_ms - last_seen_reg;
    assign since_rep  = item.now_ms - last_rep_time_reg;

    assign poll_ok   = since_poll >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.poll_interval};
    assign leave_due = active_valid_reg &&
                       (since_seen > {{(TimeWidth-CfgWidth){1'b0}}, cfg.leave_timeout});

    assign ignore_expire = (ignore_deadline_reg != '0) && (item.now_ms > ignore_deadline_reg);
    assign ignore_hit    = !ignore_expire && ignore_armed_reg &&
                           (item.now_ms <= ignore_deadline_reg) &&
                           (item.uid == ignore_uid_reg);
    assign active_hit    = active_valid_reg && (item.uid == active_uid_reg);
    assign repeat_hit    = (last_rep_uid_reg.len != '0) && (item.uid == last_rep_uid_reg) &&
                           (since_rep < {{(TimeWidth-CfgWidth){1'b0}}, cfg.repeat_window});

    assign rep_fire = (item.kind == KIND_POLL) && poll_ok && item.card_seen &&
                      !ignore_hit && !active_hit && !repeat_hit;

    always_comb
    begin
        last_poll_next       = last_poll_reg;
        active_valid_next    = active_valid_reg;
        active_uid_next      = active_uid_reg;
        last_seen_next       = last_seen_reg;
        ignore_armed_next    = ignore_armed_reg;
        ignore_uid_next      = ignore_uid_reg;
        ignore_deadline_next = ignore_deadline_reg;
        last_rep_uid_next    = last_rep_uid_reg;
        last_rep_time_next   = last_rep_time_reg;

        case (item.kind)
            KIND_IGNORE:
            begin
                ignore_uid_next      = item.uid;
                ignore_armed_next    = item.uid.len != '0;
                ignore_deadline_next = item.now_ms + item.duration_ms;
            end
            KIND_POLL:
            begin
                if (poll_ok)
                begin
                    last_poll_next = item.now_ms;
                    if (!item.card_seen)
                    begin
                        if (leave_due)
                        begin
                            active_valid_next = 1'b0;
                            active_uid_next   = '0;
                        end
                    end
                    else
                    begin
                        last_seen_next = item.now_ms;
                        if (ignore_expire)
                        begin
                            ignore_armed_next    = 1'b0;
                            ignore_uid_next      = '0;
                            ignore_deadline_next = '0;
                        end
                        if (!active_hit || ignore_hit)
                        begin
                            active_valid_next = 1'b1;
                            active_uid_next   = item.uid;
                        end
                        if (rep_fire)
                        begin
                            last_rep_uid_next  = item.uid;
                            last_rep_time_next = item.now_ms;
                        end
                    end
                end
            end
            default:
            begin
                last_poll_next = last_poll_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_poll_reg       <= '0;
            active_valid_reg    <= 1'b0;
            active_uid_reg      <= '0;
            last_seen_reg       <= '0;
            ignore_armed_reg    <= 1'b0;
            ignore_uid_reg      <= '0;
            ignore_deadline_reg <= '0;
            last_rep_uid_reg    <= '0;
            last_rep_time_reg   <= '0;
        end
        else if (go)
        begin
            last_poll_reg       <= last_poll_next;
            active_valid_reg    <= active_valid_next;
            active_uid_reg      <= active_uid_next;
            last_seen_reg       <= last_seen_next;
            ignore_armed_reg    <= ignore_armed_next;
            ignore_uid_reg      <= ignore_uid_next;
            ignore_deadline_reg <= ignore_deadline_next;
            last_rep_uid_reg    <= last_rep_uid_next;
            last_rep_time_reg   <= last_rep_time_next;
        end
    end

    assign res.report = rep_fire;
    assign res.uid    = rep_fire ? item.uid : '0;

`ifndef NO_ASSERTIONS
    a_report_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        go && rep_fire |=> active_valid_reg && (active_uid_reg == $past(item.uid)))
        else $error("reported card not active");

    a_report_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        go && rep_fire |=> last_rep_uid_reg == $past(item.uid) &&
                          last_rep_time_reg == $past(item.now_ms))
        else $error("last reported uid not updated");

    a_armed_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        ignore_armed_reg |-> ignore_uid_reg.len != '0)
        else $error("ignore armed with empty uid");

    a_inactive_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_valid_reg |-> active_uid_reg == '0)
        else $error("released card uid not cleared");

    a_no_report_on_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.kind == KIND_IGNORE |=> $stable(last_rep_time_reg))
        else $error("ignore request touched report state");
`endif

endmodule

FILE: sv/tag_uid_report_qualifier.sv
// top level: input register, qualification core and result register
// Takes one request per clock cycle unless out_ready holds back the result
// register. A request is captured in an input register, passes the
// qualification logic and lands in a result register. The qualification
// state updates in the same cycle the request moves to the result register,
// which is what sets the one-request-per-cycle rate. The input side keeps
// accepting while a result waits, until both the input and result registers
// are full. Configuration writes take effect on the next cycle.
module tag_uid_report_qualifier
    import tuq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic                   card_seen,
    input  logic [UidLoWidth-1:0]  uid_low,
    input  logic [UidHiWidth-1:0]  uid_high,
    input  logic [UidLenWidth-1:0] uid_len,
    input  logic [TimeWidth-1:0]   now_ms,
    input  logic [TimeWidth-1:0]   duration_ms,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   report,
    output logic [UidLoWidth-1:0]  rep_uid_low,
    output logic [UidHiWidth-1:0]  rep_uid_high,
    output logic [UidLenWidth-1:0] rep_uid_len,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CfgWidth-1:0]    cfg_data
);

    logic    in_vld_reg, in_vld_next;
    item_t   in_reg;
    logic    out_vld_reg, out_vld_next;
    result_t out_reg;
    logic    advance;
    logic    take;
    cfg_t    cfg;
    result_t res;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign take     = in_valid && in_ready;

    assign in_vld_next  = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.kind        <= kind_t'(kind);
            in_reg.card_seen   <= card_seen;
            in_reg.uid         <= clean_uid(uid_low, uid_high, uid_len);
            in_reg.now_ms      <= now_ms;
            in_reg.duration_ms <= duration_ms;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    tuq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tuq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid    = out_vld_reg;
    assign report       = out_reg.report;
    assign rep_uid_low  = out_reg.uid.lo;
    assign rep_uid_high = out_reg.uid.hi;
    assign rep_uid_len  = out_reg.uid.len;

endmodule
